// File: hdl/verlet_ball_wall_step_defines.svh
// Assertion macros shared by the RTL.
`ifndef VERLET_BALL_WALL_STEP_DEFINES_SVH
`define VERLET_BALL_WALL_STEP_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define VBWS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define VBWS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/vbws_pkg.sv
package vbws_pkg;

    localparam int FIELD_WIDTH   = 1280;
    localparam int FIELD_HEIGHT  = 720;
    localparam int FRAC_ONE      = 65536;
    localparam int GROUND_MARGIN = 655;

    typedef logic signed [28:0] t_pos;
    typedef logic signed [32:0] t_wide;
    typedef logic signed [31:0] t_disp;
    typedef logic signed [17:0] t_fac;
    typedef logic signed [26:0] t_grav;
    typedef logic signed [32:0] t_mul_a;
    typedef logic signed [26:0] t_mul_b;
    typedef logic signed [59:0] t_prod;
    typedef logic        [32:0] t_sq;

    typedef struct packed {
        t_grav        gravity_x;
        t_grav        gravity_y;
        logic [15:0]  time_step;
        logic [24:0]  ball_radius;
        logic [16:0]  bounce_factor;
        logic [16:0]  slide_loss;
    } t_cfg;

    typedef enum logic [2:0] {
        REG_GRAVITY_X,
        REG_GRAVITY_Y,
        REG_TIME_STEP,
        REG_BALL_RADIUS,
        REG_BOUNCE_FACTOR,
        REG_SLIDE_LOSS
    } t_reg_idx;

    localparam t_cfg CFG_RESET = '{
        gravity_x:     '0,
        gravity_y:     '0,
        time_step:     16'd1092,
        ball_radius:   25'd655360,
        bounce_factor: 17'd52429,
        slide_loss:    17'd524
    };

    localparam t_wide WALL_X     = t_wide'(FIELD_WIDTH * FRAC_ONE);
    localparam t_wide WALL_Y     = t_wide'(FIELD_HEIGHT * FRAC_ONE);
    localparam t_wide GROUND_LIM = t_wide'(FIELD_HEIGHT * FRAC_ONE - GROUND_MARGIN);
    localparam t_wide POS_MAX    = 33'sd268435455;
    localparam t_wide POS_MIN    = -33'sd268435456;
    localparam t_fac  ONE_Q16    = t_fac'(FRAC_ONE);
    localparam t_disp DISP_LIM   = t_disp'(FRAC_ONE);
    localparam t_sq   STOP_SQ    = 33'd4295;
    localparam t_prod RND_BIAS   = 60'sd32768;
    localparam t_prod ACC_BIAS   = 60'sd4294967296;

    // Clamp to the 29-bit position range.
    function automatic t_pos sat_pos(input t_wide v);
        t_pos r;
        if (v > POS_MAX) begin
            r = t_pos'(POS_MAX);
        end else if (v < POS_MIN) begin
            r = t_pos'(POS_MIN);
        end else begin
            r = t_pos'(v);
        end
        return r;
    endfunction

    // Q16 product back to Q0 of the displacement, round half up.
    function automatic t_disp round_q16(input t_prod p);
        t_prod s;
        s = p + RND_BIAS;
        return t_disp'(s >>> 16);
    endfunction

    // g*dt^2 (Q48) to g*dt^2/2 in Q16, round half up.
    function automatic t_wide half_acc(input t_prod p);
        t_prod s;
        s = p + ACC_BIAS;
        return t_wide'(s >>> 33);
    endfunction

endpackage

// File: hdl/vbws_if.sv
interface vbws_in_if;
    logic             valid;
    logic             ready;
    logic             op;
    vbws_pkg::t_pos   load_x;
    vbws_pkg::t_pos   load_y;
    vbws_pkg::t_pos   load_prev_x;
    vbws_pkg::t_pos   load_prev_y;

    modport source (output valid, op, load_x, load_y, load_prev_x, load_prev_y,
                    input ready);
    modport sink   (input valid, op, load_x, load_y, load_prev_x, load_prev_y,
                    output ready);
endinterface

interface vbws_out_if;
    logic             valid;
    logic             ready;
    vbws_pkg::t_pos   pos_x;
    vbws_pkg::t_pos   pos_y;
    logic             on_ground;
    logic             stopped;

    modport source (output valid, pos_x, pos_y, on_ground, stopped, input ready);
    modport sink   (input valid, pos_x, pos_y, on_ground, stopped, output ready);
endinterface

// File: hdl/verlet_ball_wall_step.sv
// Verlet ball with wall bounce. Holds one ball's current and previous position (Q16 px,
// 29-bit signed). A load transaction (op=1) sets both positions and returns the loaded
// current position through the output register. A step transaction (op=0) advances by
// position Verlet, runs the right, left, bottom and top wall tests in that order, then
// ground friction with a stop test, and returns the new position with on_ground/stopped
// flags. All products go through one registered multiplier under a small sequencer,
// which forms dt^2 and the two gravity terms, tests each wall, reflects the motion at
// each wall hit, applies friction with ground contact and hands off the result. The
// block is busy (ready low) for the whole step. Results sit in an output register, so
// the next transaction can be taken while the previous result waits.
// Configuration (APB, register i at byte 4*i) is sampled live and may only change while
// the block is idle.
`include "verlet_ball_wall_step_defines.svh"

module verlet_ball_wall_step (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    vbws_in_if.sink      i_in,
    vbws_out_if.source   o_out
);

    typedef enum logic [4:0] {
        S_IDLE,     // waiting for a transaction
        S_DT2,      // launch dt*dt
        S_GX,       // launch dt2*gx
        S_GY,       // x Verlet update, launch dt2*gy
        S_VY,       // y Verlet update
        S_WALL,     // test current wall, clamp on hit
        S_MA,       // launch normal * bounce
        S_MB,       // take normal, launch tangential * keep
        S_MC,       // take tangential
        S_UPD,      // previous position from displacement
        S_GND,      // ground contact test
        S_G1,       // launch dx*keep
        S_G2,       // take dx, launch dy*keep
        S_G3,       // take dy
        S_SQ1,      // range check, launch dx^2
        S_SQ2,      // take dx^2, launch dy^2
        S_SQ3,      // speed threshold
        S_DONE      // hand result to output register
    } t_state;

    typedef enum logic [1:0] {
        W_RIGHT,
        W_LEFT,
        W_BOTTOM,
        W_TOP
    } t_wall;

    vbws_pkg::t_cfg    cfg;

    t_state            r_state, n_state;
    t_wall             r_wall, n_wall;
    vbws_pkg::t_pos    r_px, n_px;
    vbws_pkg::t_pos    r_py, n_py;
    vbws_pkg::t_pos    r_lx, n_lx;
    vbws_pkg::t_pos    r_ly, n_ly;
    logic [31:0]       r_dt2, n_dt2;
    vbws_pkg::t_disp   r_dx, n_dx;
    vbws_pkg::t_disp   r_dy, n_dy;
    logic [31:0]       r_sq, n_sq;
    logic              r_gnd, n_gnd;
    logic              r_stop, n_stop;
    logic              r_ovalid, n_ovalid;
    vbws_pkg::t_pos    r_opx, n_opx;
    vbws_pkg::t_pos    r_opy, n_opy;
    logic              r_ognd, n_ognd;
    logic              r_ostop, n_ostop;

    vbws_pkg::t_mul_a  mul_a;
    vbws_pkg::t_mul_b  mul_b;
    vbws_pkg::t_prod   mul_p;

    vbws_pkg::t_wide   rad;
    vbws_pkg::t_wide   wlim;
    vbws_pkg::t_wide   hlim;
    vbws_pkg::t_fac    keep;
    vbws_pkg::t_fac    bounce;
    vbws_pkg::t_disp   cur_dx;
    vbws_pkg::t_disp   cur_dy;
    vbws_pkg::t_disp   norm;
    vbws_pkg::t_disp   tang;
    vbws_pkg::t_disp   rq;
    logic              y_normal;
    logic              wall_hit;
    logic              in_range;
    vbws_pkg::t_sq     sq_sum;

    vbws_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    vbws_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // Wall limits and factors straight from the config registers.
    assign rad    = vbws_pkg::t_wide'({8'd0, cfg.ball_radius});
    assign wlim   = vbws_pkg::WALL_X - rad;
    assign hlim   = vbws_pkg::WALL_Y - rad;
    assign keep   = vbws_pkg::ONE_Q16 - vbws_pkg::t_fac'({1'b0, cfg.slide_loss});
    assign bounce = vbws_pkg::t_fac'({1'b0, cfg.bounce_factor});

    assign cur_dx = vbws_pkg::t_disp'(r_px) - vbws_pkg::t_disp'(r_lx);
    assign cur_dy = vbws_pkg::t_disp'(r_py) - vbws_pkg::t_disp'(r_ly);

    // Bottom and top walls have y as the normal axis.
    assign y_normal = (r_wall == W_BOTTOM) || (r_wall == W_TOP);
    assign norm     = y_normal ? r_dy : r_dx;
    assign tang     = y_normal ? r_dx : r_dy;
    assign rq       = vbws_pkg::round_q16(mul_p);

    always_comb begin
        unique case (r_wall)
            W_RIGHT:  wall_hit = vbws_pkg::t_wide'(r_px) > wlim;
            W_LEFT:   wall_hit = vbws_pkg::t_wide'(r_px) < rad;
            W_BOTTOM: wall_hit = vbws_pkg::t_wide'(r_py) > hlim;
            W_TOP:    wall_hit = vbws_pkg::t_wide'(r_py) < rad;
            default:  wall_hit = 1'b0;
        endcase
    end

    // Squares only when both parts fit 17 bits signed; this also bounds the sum.
    assign in_range = (r_dx > -vbws_pkg::DISP_LIM) && (r_dx < vbws_pkg::DISP_LIM) &&
                      (r_dy > -vbws_pkg::DISP_LIM) && (r_dy < vbws_pkg::DISP_LIM);
    assign sq_sum   = {1'b0, r_sq} + {1'b0, mul_p[31:0]};

    // Multiplier operand select
    always_comb begin
        unique case (r_state)
            S_DT2: begin
                mul_a = vbws_pkg::t_mul_a'({17'd0, cfg.time_step});
                mul_b = vbws_pkg::t_mul_b'({11'd0, cfg.time_step});
            end
            S_GX: begin
                mul_a = vbws_pkg::t_mul_a'({1'b0, mul_p[31:0]});
                mul_b = cfg.gravity_x;
            end
            S_GY: begin
                mul_a = vbws_pkg::t_mul_a'({1'b0, r_dt2});
                mul_b = cfg.gravity_y;
            end
            S_MA: begin
                mul_a = -vbws_pkg::t_mul_a'(norm);
                mul_b = vbws_pkg::t_mul_b'(bounce);
            end
            S_MB: begin
                mul_a = vbws_pkg::t_mul_a'(tang);
                mul_b = vbws_pkg::t_mul_b'(keep);
            end
            S_G1: begin
                mul_a = vbws_pkg::t_mul_a'(r_dx);
                mul_b = vbws_pkg::t_mul_b'(keep);
            end
            S_G2: begin
                mul_a = vbws_pkg::t_mul_a'(r_dy);
                mul_b = vbws_pkg::t_mul_b'(keep);
            end
            S_SQ1: begin
                mul_a = vbws_pkg::t_mul_a'(r_dx);
                mul_b = vbws_pkg::t_mul_b'($signed(r_dx[16:0]));
            end
            S_SQ2: begin
                mul_a = vbws_pkg::t_mul_a'(r_dy);
                mul_b = vbws_pkg::t_mul_b'($signed(r_dy[16:0]));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_wall   = r_wall;
        n_px     = r_px;
        n_py     = r_py;
        n_lx     = r_lx;
        n_ly     = r_ly;
        n_dt2    = r_dt2;
        n_dx     = r_dx;
        n_dy     = r_dy;
        n_sq     = r_sq;
        n_gnd    = r_gnd;
        n_stop   = r_stop;
        n_ovalid = r_ovalid && !o_out.ready;
        n_opx    = r_opx;
        n_opy    = r_opy;
        n_ognd   = r_ognd;
        n_ostop  = r_ostop;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_gnd  = 1'b0;
                    n_stop = 1'b0;
                    if (i_in.op) begin
                        n_px    = i_in.load_x;
                        n_py    = i_in.load_y;
                        n_lx    = i_in.load_prev_x;
                        n_ly    = i_in.load_prev_y;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_DT2;
                    end
                end
            end
            S_DT2: n_state = S_GX;
            S_GX: begin
                n_dt2   = mul_p[31:0];
                n_state = S_GY;
            end
            S_GY: begin
                // x' = 2x - x_prev + g*dt^2/2
                n_px    = vbws_pkg::sat_pos(vbws_pkg::t_wide'(r_px) + vbws_pkg::t_wide'(r_px)
                                            - vbws_pkg::t_wide'(r_lx)
                                            + vbws_pkg::half_acc(mul_p));
                n_lx    = r_px;
                n_state = S_VY;
            end
            S_VY: begin
                n_py    = vbws_pkg::sat_pos(vbws_pkg::t_wide'(r_py) + vbws_pkg::t_wide'(r_py)
                                            - vbws_pkg::t_wide'(r_ly)
                                            + vbws_pkg::half_acc(mul_p));
                n_ly    = r_py;
                n_wall  = W_RIGHT;
                n_state = S_WALL;
            end
            S_WALL: begin
                if (wall_hit) begin
                    // displacement taken before the clamp
                    n_dx = cur_dx;
                    n_dy = cur_dy;
                    unique case (r_wall)
                        W_RIGHT:  n_px = vbws_pkg::t_pos'(wlim);
                        W_LEFT:   n_px = vbws_pkg::t_pos'(rad);
                        W_BOTTOM: n_py = vbws_pkg::t_pos'(hlim);
                        W_TOP:    n_py = vbws_pkg::t_pos'(rad);
                        default: ;
                    endcase
                    n_state = S_MA;
                end else if (r_wall == W_TOP) begin
                    n_state = S_GND;
                end else begin
                    n_wall = t_wall'(r_wall + 2'd1);
                end
            end
            S_MA: n_state = S_MB;
            S_MB: begin
                if (y_normal) begin
                    n_dy = rq;
                end else begin
                    n_dx = rq;
                end
                // bottom wall keeps the tangential part
                n_state = (r_wall == W_BOTTOM) ? S_UPD : S_MC;
            end
            S_MC: begin
                if (y_normal) begin
                    n_dx = rq;
                end else begin
                    n_dy = rq;
                end
                n_state = S_UPD;
            end
            S_UPD: begin
                n_lx = vbws_pkg::sat_pos(vbws_pkg::t_wide'(r_px) - vbws_pkg::t_wide'(r_dx));
                n_ly = vbws_pkg::sat_pos(vbws_pkg::t_wide'(r_py) - vbws_pkg::t_wide'(r_dy));
                if (r_gnd) begin
                    n_state = S_DONE;
                end else if (r_wall == W_TOP) begin
                    n_state = S_GND;
                end else begin
                    n_wall  = t_wall'(r_wall + 2'd1);
                    n_state = S_WALL;
                end
            end
            S_GND: begin
                if (vbws_pkg::t_wide'(r_py) + rad >= vbws_pkg::GROUND_LIM) begin
                    n_gnd   = 1'b1;
                    n_dx    = cur_dx;
                    n_dy    = cur_dy;
                    n_state = S_G1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_G1: n_state = S_G2;
            S_G2: begin
                n_dx    = rq;
                n_state = S_G3;
            end
            S_G3: begin
                n_dy    = rq;
                n_state = S_SQ1;
            end
            S_SQ1: n_state = in_range ? S_SQ2 : S_UPD;
            S_SQ2: begin
                n_sq    = mul_p[31:0];
                n_state = S_SQ3;
            end
            S_SQ3: begin
                // squared speed under 1e-6 px^2: kill residual motion
                if (sq_sum < vbws_pkg::STOP_SQ) begin
                    n_dx   = '0;
                    n_dy   = '0;
                    n_stop = 1'b1;
                end
                n_state = S_UPD;
            end
            S_DONE: begin
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid = 1'b1;
                    n_opx    = r_px;
                    n_opy    = r_py;
                    n_ognd   = r_gnd;
                    n_ostop  = r_stop;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wall   <= W_RIGHT;
            r_px     <= '0;
            r_py     <= '0;
            r_lx     <= '0;
            r_ly     <= '0;
            r_gnd    <= 1'b0;
            r_stop   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wall   <= n_wall;
            r_px     <= n_px;
            r_py     <= n_py;
            r_lx     <= n_lx;
            r_ly     <= n_ly;
            r_dt2    <= n_dt2;
            r_dx     <= n_dx;
            r_dy     <= n_dy;
            r_sq     <= n_sq;
            r_gnd    <= n_gnd;
            r_stop   <= n_stop;
            r_ovalid <= n_ovalid;
            r_opx    <= n_opx;
            r_opy    <= n_opy;
            r_ognd   <= n_ognd;
            r_ostop  <= n_ostop;
        end
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_ovalid;
    assign o_out.pos_x     = r_opx;
    assign o_out.pos_y     = r_opy;
    assign o_out.on_ground = r_ognd;
    assign o_out.stopped   = r_ostop;

    `VBWS_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready, "transaction taken while busy")
    `VBWS_ASSERT_IMP(a_stop_needs_ground, i_clk, i_rst_n, o_out.valid, !o_out.stopped || o_out.on_ground, "stopped without ground contact")
    `VBWS_ASSERT_IMP(a_square_on_ground, i_clk, i_rst_n, r_state == S_SQ1 || r_state == S_SQ2 || r_state == S_SQ3, r_gnd, "speed test off the ground")
    `VBWS_ASSERT_IMP(a_stop_zero_disp, i_clk, i_rst_n, r_state == S_UPD && r_stop, r_dx == '0 && r_dy == '0, "stop left residual displacement")

endmodule

// File: hdl/vbws_mul.sv
// Shared signed multiplier, product registered.
module vbws_mul (
    input  logic             i_clk,
    input  vbws_pkg::t_mul_a i_a,
    input  vbws_pkg::t_mul_b i_b,
    output vbws_pkg::t_prod  o_p
);

    vbws_pkg::t_prod r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

// File: hdl/vbws_apb.sv
// Configuration register file, APB write/read.
module vbws_apb (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [4:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready,
    output vbws_pkg::t_cfg  o_cfg
);

    vbws_pkg::t_cfg     r_cfg;
    vbws_pkg::t_cfg     n_cfg;
    vbws_pkg::t_reg_idx idx;
    logic               wr_en;

    assign idx    = vbws_pkg::t_reg_idx'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (idx)
                vbws_pkg::REG_GRAVITY_X:     n_cfg.gravity_x     = pwdata[26:0];
                vbws_pkg::REG_GRAVITY_Y:     n_cfg.gravity_y     = pwdata[26:0];
                vbws_pkg::REG_TIME_STEP:     n_cfg.time_step     = pwdata[15:0];
                vbws_pkg::REG_BALL_RADIUS:   n_cfg.ball_radius   = pwdata[24:0];
                vbws_pkg::REG_BOUNCE_FACTOR: n_cfg.bounce_factor = pwdata[16:0];
                vbws_pkg::REG_SLIDE_LOSS:    n_cfg.slide_loss    = pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            vbws_pkg::REG_GRAVITY_X:     prdata = 32'(r_cfg.gravity_x);
            vbws_pkg::REG_GRAVITY_Y:     prdata = 32'(r_cfg.gravity_y);
            vbws_pkg::REG_TIME_STEP:     prdata = {16'd0, r_cfg.time_step};
            vbws_pkg::REG_BALL_RADIUS:   prdata = {7'd0, r_cfg.ball_radius};
            vbws_pkg::REG_BOUNCE_FACTOR: prdata = {15'd0, r_cfg.bounce_factor};
            vbws_pkg::REG_SLIDE_LOSS:    prdata = {15'd0, r_cfg.slide_loss};
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= vbws_pkg::CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule
